### rtl/fud_pkg.sv
// Shared types, constants and helper functions for the file URI percent decoder.
`timescale 1ns / 1ps
package fud_pkg;

	localparam int unsigned PfxLen   = 7;
	localparam int unsigned BurstMax = 7;
	localparam logic [7:0]  Pct      = 8'h25;

	typedef enum logic [1:0] {
		PH_PREFIX = 2'd0,
		PH_DECODE = 2'd1,
		PH_PASS   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [BurstMax-1:0][7:0] bytes;
		logic [2:0]               cnt;
		logic                     np;
		logic                     empty;
		logic                     last;
	} burst_t;

	function automatic logic [7:0] pfx_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h66;
			3'd1:    c = 8'h69;
			3'd2:    c = 8'h6C;
			3'd3:    c = 8'h65;
			3'd4:    c = 8'h3A;
			3'd5:    c = 8'h2F;
			3'd6:    c = 8'h2F;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b0, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b0, 4'(c - 8'h57)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

endpackage

### rtl/file_uri_percent_decoder_core.sv
// Top level of the file URI percent decoder: input register, decode and result buffer.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall | in_byte, in_last
//  out     | output    | out_valid/out_stall | out_byte, out_last, no_prefix, is_empty
//
// An item is registered and decoded combinationally into a burst of zero to seven
// results, handed out one result per cycle by the result buffer while out_stall is low.
// Items giving one result sustain one item per cycle while out_stall is low; a burst of n
// results holds the input register until the single output port hands out the last.
// arst_n clears the input register's valid flag, decode state and buffer count.
// in_stall rises only while the input register is full and the buffer cannot load.
`timescale 1ns / 1ps
module file_uri_percent_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       no_prefix,
	output logic       is_empty
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	logic            can_load;
	logic            consume;
	logic            accept;
	logic [2:0]      rem;
	fud_pkg::burst_t burst;

	assign consume  = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !consume);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	fud_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.advance (consume),
		.burst   (burst)
	);

	fud_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.load      (consume),
		.can_load  (can_load),
		.rem       (rem),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.no_prefix (no_prefix),
		.is_empty  (is_empty)
	);

	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> out_last && !no_prefix)
		else $error("empty result not a lone final result");

	a_hold_on_burst: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rem > 3'd1 |-> in_stall)
		else $error("input taken while a burst is still pending");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		consume |-> burst.cnt <= 3'(fud_pkg::BurstMax) && (!burst.empty || burst.cnt == 3'd1))
		else $error("malformed burst");

	a_rem_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !consume |=> rem == $past(rem) - 3'd1)
		else $error("result buffer count did not advance");

endmodule

### rtl/fud_decode.sv
// Per-URI decode state and the result burst produced by one item.
`timescale 1ns / 1ps
module fud_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_s1,
	input  logic                last_s1,
	input  logic                advance,
	output fud_pkg::burst_t     burst
);

	fud_pkg::phase_t phase_q, phase_d;
	logic [2:0]      pm_q, pm_d;
	logic [1:0]      pc_q, pc_d;
	logic [7:0]      pch_q, pch_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fud_pkg::PH_PREFIX;
			pm_q    <= 3'd0;
			pc_q    <= 2'd0;
			pch_q   <= 8'h00;
		end else if (advance) begin
			phase_q <= phase_d;
			pm_q    <= pm_d;
			pc_q    <= pc_d;
			pch_q   <= pch_d;
		end
	end

	always_comb begin
		logic [4:0] hv_b;
		logic [4:0] hv_p;
		logic       is_hex;
		logic       is_pct;
		logic       do_fresh;
		logic [2:0] m1;
		logic [2:0] k;
		fud_pkg::burst_t bo;

		hv_b     = fud_pkg::hex_val(byte_s1);
		hv_p     = fud_pkg::hex_val(pch_q);
		is_hex   = !hv_b[4];
		is_pct   = (byte_s1 == fud_pkg::Pct);
		do_fresh = 1'b0;
		m1       = pm_q + 3'd1;
		k        = 3'd0;
		bo       = '0;
		bo.last  = last_s1;
		phase_d  = phase_q;
		pm_d     = pm_q;
		pc_d     = pc_q;
		pch_d    = pch_q;

		unique case (phase_q)
			fud_pkg::PH_PREFIX: begin
				bo.np = 1'b1;
				for (int i = 0; i < fud_pkg::BurstMax; i++) begin
					bo.bytes[i] = (3'(i) < pm_q) ? fud_pkg::pfx_char(3'(i)) : byte_s1;
				end
				if (byte_s1 == fud_pkg::pfx_char(pm_q)) begin
					pm_d = m1;
					if (m1 == 3'(fud_pkg::PfxLen)) begin
						phase_d = fud_pkg::PH_DECODE;
						if (last_s1) begin
							bo.bytes = '0;
							bo.cnt   = 3'd1;
							bo.np    = 1'b0;
							bo.empty = 1'b1;
						end
					end else if (last_s1) begin
						bo.cnt = m1;
					end
				end else begin
					bo.cnt  = m1;
					phase_d = fud_pkg::PH_PASS;
				end
			end
			fud_pkg::PH_DECODE: begin
				if (pc_q == 2'd0) begin
					do_fresh = 1'b1;
				end else if (pc_q == 2'd1) begin
					if (is_hex) begin
						pc_d  = 2'd2;
						pch_d = byte_s1;
					end else begin
						bo.bytes[k] = fud_pkg::Pct;
						k = k + 3'd1;
						do_fresh = 1'b1;
					end
				end else begin
					if (is_hex) begin
						bo.bytes[k] = {hv_p[3:0], hv_b[3:0]};
						k = k + 3'd1;
						pc_d = 2'd0;
					end else begin
						bo.bytes[k] = fud_pkg::Pct;
						k = k + 3'd1;
						bo.bytes[k] = pch_q;
						k = k + 3'd1;
						do_fresh = 1'b1;
					end
				end
				if (do_fresh) begin
					if (is_pct) begin
						pc_d = 2'd1;
					end else begin
						pc_d = 2'd0;
						bo.bytes[k] = byte_s1;
						k = k + 3'd1;
					end
				end
				if (last_s1) begin
					if (pc_d != 2'd0) begin
						bo.bytes[k] = fud_pkg::Pct;
						k = k + 3'd1;
					end
					if (pc_d == 2'd2) begin
						bo.bytes[k] = pch_d;
						k = k + 3'd1;
					end
				end
				bo.cnt = k;
			end
			default: begin
				bo.bytes[0] = byte_s1;
				bo.cnt      = 3'd1;
				bo.np       = 1'b1;
			end
		endcase

		if (last_s1) begin
			phase_d = fud_pkg::PH_PREFIX;
			pm_d    = 3'd0;
			pc_d    = 2'd0;
			pch_d   = 8'h00;
		end
		burst = bo;
	end

endmodule

### rtl/fud_emit.sv
// Result buffer that holds one burst and hands it out one item per cycle while out_stall is low.
`timescale 1ns / 1ps
module fud_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  fud_pkg::burst_t burst,
	input  logic            load,
	output logic            can_load,
	output logic [2:0]      rem,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            out_last,
	output logic            no_prefix,
	output logic            is_empty
);

	logic [fud_pkg::BurstMax-1:0][7:0] buf_q;
	logic [2:0]                        rem_q;
	logic                              np_q;
	logic                              empty_q;
	logic                              last_q;
	logic                              take;
	logic                              fill;

	assign take     = (rem_q != 3'd0) && !out_stall;
	assign can_load = (rem_q == 3'd0) || ((rem_q == 3'd1) && !out_stall);
	assign fill     = load && (burst.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (fill) begin
			rem_q <= burst.cnt;
		end else if (take) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fill) begin
			buf_q   <= burst.bytes;
			np_q    <= burst.np;
			empty_q <= burst.empty;
			last_q  <= burst.last;
		end else if (take) begin
			buf_q <= {8'h00, buf_q[fud_pkg::BurstMax-1:1]};
		end
	end

	assign rem       = rem_q;
	assign out_valid = (rem_q != 3'd0);
	assign out_byte  = buf_q[0];
	assign out_last  = last_q && (rem_q == 3'd1);
	assign no_prefix = np_q;
	assign is_empty  = empty_q;

endmodule
